FILE: hw/rtl/wheel_speed_odometer_assert.svh
// ---------------------------------------------------------------------------
// Wheel speed odometer assertion macros
// Shorthands for clocked checks with a synchronous active-low reset.
// ---------------------------------------------------------------------------
`ifndef WHEEL_SPEED_ODOMETER_ASSERT_SVH
`define WHEEL_SPEED_ODOMETER_ASSERT_SVH

// Condition in one cycle implies a consequence in the same cycle.
`define WSO_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define WSO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/wso_pkg.sv
// ---------------------------------------------------------------------------
// Wheel speed odometer package
// Shared types and fixed constants of the speed and odometer datapath.
// ---------------------------------------------------------------------------
package wso_pkg;

  // Request kinds carried on the input tuser
  localparam logic [1:0] REQ_SAMPLE   = 2'd0;
  localparam logic [1:0] REQ_ODO_LOAD = 2'd1;
  localparam logic [1:0] REQ_TRIP_CLR = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_SPEED_GAIN  = 2'd0;
  localparam logic [1:0] CFG_SPEED_LIMIT = 2'd1;
  localparam logic [1:0] CFG_SAMPLES_UPD = 2'd2;

  // Fixed widths of the rpm magnitude, the gain and their product
  localparam int MAG_W  = 15;
  localparam int GAIN_W = 16;
  localparam int PROD_W = MAG_W + GAIN_W;

  // Odometer widths and wrap point in metres
  localparam int ODO_W  = 30;
  localparam int TRIP_W = 32;
  localparam logic [ODO_W:0] ODO_WRAP = 31'd1000000000;

  // Status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } wso_unit_st_t;

endpackage

FILE: hw/rtl/wso_mul.sv
// ---------------------------------------------------------------------------
// Wheel speed odometer serial multiplier
// Shift-add multiply of rpm magnitude by gain, one multiplier bit a cycle.
// ---------------------------------------------------------------------------
module wso_mul
  import wso_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MAG_W-1:0]  mag,
  input  logic [GAIN_W-1:0] gain,
  output logic [PROD_W-1:0] prod,
  output wso_unit_st_t      st
);

  localparam int CW = $clog2(MAG_W + 1);

  logic [MAG_W-1:0]  a_r, a_nxt;
  logic [GAIN_W-1:0] b_r, b_nxt;
  logic [PROD_W-1:0] p_r, p_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    p_nxt    = p_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = mag;
      b_nxt    = gain;
      p_nxt    = '0;
      cnt_nxt  = CW'(MAG_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // MSB first: double the partial product, add gain on a set bit
      p_nxt   = {p_r[PROD_W-2:0], 1'b0} + (a_r[MAG_W-1] ? PROD_W'(b_r) : '0);
      a_nxt   = {a_r[MAG_W-2:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    p_r <= p_nxt;
  end

  assign prod    = p_r;
  assign st.busy = busy_r;
  assign st.done = done_r;

endmodule

FILE: hw/rtl/wso_cdiv.sv
// ---------------------------------------------------------------------------
// Wheel speed odometer serial constant divider
// Restoring division by a fixed divisor, one quotient bit a cycle.
// ---------------------------------------------------------------------------
module wso_cdiv
  import wso_pkg::*;
#(
  parameter int W   = 32,
  parameter int DIV = 100
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  output logic [W-1:0] quotient,
  output wso_unit_st_t st
);

  // DIV of 2 or more
  localparam int          RW    = $clog2(DIV);
  localparam int          CW    = $clog2(W + 1);
  localparam logic [RW:0] DIV_V = (RW + 1)'(DIV);

  logic [W-1:0]  q_r, q_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [RW:0]   trial;
  logic          ge;

  assign trial = {rem_r, q_r[W-1]};
  assign ge    = (trial >= DIV_V);

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift the next dividend bit into the remainder, quotient bit in at LSB
      rem_nxt = ge ? RW'(trial - DIV_V) : trial[RW-1:0];
      q_nxt   = {q_r[W-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign quotient = q_r;
  assign st.busy  = busy_r;
  assign st.done  = done_r;

endmodule

FILE: hw/rtl/wheel_speed_odometer.sv
// ---------------------------------------------------------------------------
// Wheel speed odometer
// Turns wheel rpm samples into speed, odometer and trip B distance.
// ---------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                Content
//  in_      slave      in_tvalid / in_tready    request kind, rpm, odometer load
//  out_     master     out_tvalid / out_tready  speed, odometer, trip B
//  cfg_     slave      cfg_valid / cfg_ready    register index and write data
//
//  One item is worked at a time; the input takes a new item once the result
//  of the previous one sits in the output register. Work per item:
//    load, trip clear, zero rpm: the /100 display dividers, then done
//    sample without update:      add the serial multiplier and the clamp
//    sample with update:         add the serial /18, the odometer and the trip
//                                steps, or only the trip step when the speed is zero
//  Reset (rst_n low at a clock edge) clears the control, speed, odometer, trip
//  and count state but not the data registers; configuration returns to gain
//  5925, limit 99, ten samples per update. A stalled output holds the finished
//  item and blocks only the next result.
module wheel_speed_odometer
  import wso_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // input items
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // wheel_rpm[15:0], odo_load_value[45:16], zero pad
  input  logic [1:0]   in_tuser,   // req_type[1:0]
  // result items
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,  // speed_kmh[6:0], odo_metres[36:7],
                                   // odo_display[60:37], trip_metres[92:61],
                                   // trip_display[118:93], zero pad
  // configuration writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  // Speed register: Q7.FRAC_BITS; product scaled by a fixed shift
  localparam int SPW  = 7 + FRAC_BITS;
  localparam int LSH  = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
  localparam int RSH  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int PW   = PROD_W + LSH;
  localparam int S5W  = SPW + 3;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_MUL   = 10'b0000000010,
    S_CLAMP = 10'b0000000100,
    S_STEP  = 10'b0000001000,
    S_STEPW = 10'b0000010000,
    S_ODO   = 10'b0000100000,
    S_TRIP  = 10'b0001000000,
    S_DISP  = 10'b0010000000,
    S_DISPW = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } wso_state_t;

  wso_state_t state_r, state_nxt;

  // Configuration
  logic [15:0] gain_r;
  logic [6:0]  limit_r;
  logic [7:0]  spu_r;

  // Block state
  logic [SPW-1:0]       speed_r, speed_nxt;
  logic [7:0]           cnt_r, cnt_nxt;
  logic [FRAC_BITS-1:0] frac_r, frac_nxt;
  logic [ODO_W-1:0]     odo_r, odo_nxt;
  logic [ODO_W-1:0]     tstart_r, tstart_nxt;
  logic [TRIP_W-1:0]    trip_r, trip_nxt;

  // Output register
  logic         out_valid_r, out_valid_nxt;
  logic [119:0] out_data_r, out_data_nxt;

  // Serial units
  wso_unit_st_t        mul_st, stp_st, odd_st, trd_st;
  logic [PROD_W-1:0]   prod;
  logic [S5W-1:0]      stp_q;
  logic [ODO_W-1:0]    odd_q;
  logic [TRIP_W-1:0]   trd_q;
  logic                mul_start, stp_start, dsp_start;

  // Request decode
  logic                in_accept;
  logic [15:0]         rpm;
  logic [15:0]         abs_rpm;
  logic [MAG_W-1:0]    mag;
  logic                out_free;

  // Clamp and update arithmetic
  logic [PW-1:0]       spd_sc;
  logic [PW-1:0]       spd_lim;
  logic [SPW-1:0]      spd_cl;
  logic [7:0]          cnt_inc;
  logic [7:0]          spu_eff;
  logic [S5W-1:0]      spd_x5;
  logic [SPW:0]        acc;
  logic [ODO_W:0]      odo_sum;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Magnitude of the signed sample, most negative value saturated
  assign rpm     = in_tdata[15:0];
  assign abs_rpm = rpm[15] ? (~rpm + 16'd1) : rpm;
  assign mag     = abs_rpm[15] ? {MAG_W{1'b1}} : abs_rpm[MAG_W-1:0];

  // Scale product to FRAC_BITS (truncating) and clamp to the speed limit
  assign spd_sc  = (PW'(prod) << LSH) >> RSH;
  assign spd_lim = PW'(limit_r) << FRAC_BITS;
  assign spd_cl  = (spd_sc > spd_lim) ? SPW'(spd_lim) : SPW'(spd_sc);

  assign cnt_inc = cnt_r + 8'd1;
  assign spu_eff = (spu_r == 8'd0) ? 8'd1 : spu_r;

  // Metres per update: speed * 5 / 18, the divide done serially
  assign spd_x5  = (S5W'(speed_r) << 2) + S5W'(speed_r);
  assign acc     = (SPW + 1)'(frac_r) + (SPW + 1)'(stp_q);
  assign odo_sum = (ODO_W + 1)'(odo_r) + (ODO_W + 1)'(acc[SPW:FRAC_BITS]);

  assign mul_start = in_accept && (in_tuser == REQ_SAMPLE) && (mag != '0);
  assign stp_start = (state_r == S_STEP);
  assign dsp_start = (state_r == S_DISP);

  wso_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .mag   (mag),
    .gain  (gain_r),
    .prod  (prod),
    .st    (mul_st)
  );

  wso_cdiv #(.W(S5W), .DIV(18)) u_step_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (stp_start),
    .dividend (spd_x5),
    .quotient (stp_q),
    .st       (stp_st)
  );

  wso_cdiv #(.W(ODO_W), .DIV(100)) u_odo_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dsp_start),
    .dividend (odo_r),
    .quotient (odd_q),
    .st       (odd_st)
  );

  wso_cdiv #(.W(TRIP_W), .DIV(100)) u_trip_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dsp_start),
    .dividend (trip_r),
    .quotient (trd_q),
    .st       (trd_st)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    speed_nxt     = speed_r;
    cnt_nxt       = cnt_r;
    frac_nxt      = frac_r;
    odo_nxt       = odo_r;
    tstart_nxt    = tstart_r;
    trip_nxt      = trip_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_DISP;
          case (in_tuser)
            REQ_SAMPLE: begin
              // a zero sample stops the speed and does not count
              if (mag == '0) begin
                speed_nxt = '0;
              end else begin
                state_nxt = S_MUL;
              end
            end
            REQ_ODO_LOAD: begin
              odo_nxt = in_tdata[45:16];
            end
            REQ_TRIP_CLR: begin
              trip_nxt   = '0;
              tstart_nxt = odo_r;
            end
            default: begin
              // unused kind: report the state as it is
            end
          endcase
        end
      end
      S_MUL: begin
        if (mul_st.done) begin
          state_nxt = S_CLAMP;
        end
      end
      S_CLAMP: begin
        speed_nxt = spd_cl;
        if (cnt_inc >= spu_eff) begin
          cnt_nxt   = '0;
          // zero speed leaves the odometer alone, trip B is still rebuilt
          state_nxt = (spd_cl != '0) ? S_STEP : S_TRIP;
        end else begin
          cnt_nxt   = cnt_inc;
          state_nxt = S_DISP;
        end
      end
      S_STEP: begin
        state_nxt = S_STEPW;
      end
      S_STEPW: begin
        if (stp_st.done) begin
          state_nxt = S_ODO;
        end
      end
      S_ODO: begin
        // keep the fraction bits, move whole metres, wrap at the limit
        frac_nxt  = acc[FRAC_BITS-1:0];
        odo_nxt   = (odo_sum >= ODO_WRAP) ? '0 : odo_sum[ODO_W-1:0];
        state_nxt = S_TRIP;
      end
      S_TRIP: begin
        trip_nxt  = TRIP_W'(odo_r) - TRIP_W'(tstart_r);
        state_nxt = S_DISP;
      end
      S_DISP: begin
        state_nxt = S_DISPW;
      end
      S_DISPW: begin
        if (!odd_st.busy && !trd_st.busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold here until the output register can take the item
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0,
                           trd_q[25:0],
                           trip_r,
                           odd_q[23:0],
                           odo_r,
                           speed_r[SPW-1:FRAC_BITS]};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gain_r      <= 16'd5925;
      limit_r     <= 7'd99;
      spu_r       <= 8'd10;
      speed_r     <= '0;
      cnt_r       <= '0;
      frac_r      <= '0;
      odo_r       <= '0;
      tstart_r    <= '0;
      trip_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      speed_r     <= speed_nxt;
      cnt_r       <= cnt_nxt;
      frac_r      <= frac_nxt;
      odo_r       <= odo_nxt;
      tstart_r    <= tstart_nxt;
      trip_r      <= trip_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SPEED_GAIN:  gain_r  <= cfg_data;
          CFG_SPEED_LIMIT: limit_r <= cfg_data[6:0];
          CFG_SAMPLES_UPD: spu_r   <= cfg_data[7:0];
          default: begin
            // no register at this index: drop the write
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // -------------------------------------------------------------------------
  // Checks
  // -------------------------------------------------------------------------
  `include "wheel_speed_odometer_assert.svh"

  `WSO_ASSERT_NEXT(a_done_loads_out, (state_r == S_DONE) && out_free, out_valid_r && (state_r == S_IDLE), "finished item not moved to output")
  `WSO_ASSERT_NEXT(a_odo_only_on_update, (state_r != S_ODO) && !(in_accept && (in_tuser == REQ_ODO_LOAD)), $stable(odo_r), "odometer changed outside update or load")
  `WSO_ASSERT_SAME(a_mul_alone, mul_st.busy, !stp_st.busy && !odd_st.busy && !trd_st.busy, "serial units overlap")

endmodule
